// File: rtl/aopwm_pkg.sv
`default_nettype none

package aopwm_pkg;

  localparam int DEF_MAX_LEN      = 8;
  localparam int DEF_SAMPLE_WIDTH = 32;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CNT_W      = 32;

  // result beat layout, lowest bit first
  localparam int OUT_MATCH_LSB = 0;
  localparam int OUT_START_LSB = 1;
  localparam int OUT_TOTAL_LSB = OUT_START_LSB + CNT_W;
  localparam int OUT_FREQ_LSB  = OUT_TOTAL_LSB + CNT_W;
  localparam int OUT_BITS      = OUT_FREQ_LSB + 1;
  localparam int OUT_W         = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_LEN   = 3'd0,
    REG_PATTERN_RANKS = 3'd1,
    REG_MAX_RANK_DEV  = 3'd2,
    REG_MAX_TOTAL_DEV = 3'd3,
    REG_MIN_SUPPORT   = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last_pos;
    logic out_free;
  } status_t;

  function automatic logic [3:0] pat_value(input logic [31:0] ranks, input int p);
    logic [31:0] sh;
    sh = '0;
    if (p < 8) begin
      sh = ranks >> (4 * p);
    end
    return sh[3:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/approx_order_preserving_window_match_top.sv
// Order-preserving window matcher.
// Input stream: s_axis_tdata carries one two's complement sample, s_axis_tlast
// marks the last sample of a sequence. One result beat leaves on m_axis for
// every input beat; m_axis_tlast echoes the input's tlast.
// Result beat: window match flag, window start index, saturating match count
// and, on the last beat of a sequence, the frequent flag (count >= min_support).
// Configuration goes through cfg_we_i / cfg_addr_i / cfg_wdata_i, one register
// per cycle, and must be written only while the block is idle (unenforced).
// Ranking: an accepted sample steps through the pattern_len window positions
// (effective pattern_len, 2..MAX_LEN) in the rank unit, which compares each
// position against all window entries at once. The block takes no new sample
// until the current one has been ranked and its result loaded into the output
// register.
// A result waits in the output register; the next sample is accepted and
// ranked meanwhile, and only the final load stalls until m_axis_tready frees
// that register.
// Reset clears the configuration to its defaults, empties the window and
// zeroes the sample index and match count; sequence end does the same for
// the window fill, index and count.
`default_nettype none

module approx_order_preserving_window_match_top #(
  parameter int MAX_LEN      = aopwm_pkg::DEF_MAX_LEN,
  parameter int SAMPLE_WIDTH = aopwm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [aopwm_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [aopwm_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // sample, zero padded to bytes
  input  logic [((SAMPLE_WIDTH + 7) / 8) * 8-1:0] s_axis_tdata,
  input  logic                                   s_axis_tlast,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // window_match, window_start[31:0], match_total[31:0], is_frequent, zero pad
  output logic [aopwm_pkg::OUT_W-1:0]            m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import aopwm_pkg::*;

  cmd_t    cmd;
  status_t status;

  logic             window_match, is_frequent;
  logic [CNT_W-1:0] window_start, match_total;

  aopwm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  aopwm_datapath #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .last_i         (s_axis_tlast),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .window_match_o (window_match),
    .window_start_o (window_start),
    .match_total_o  (match_total),
    .is_frequent_o  (is_frequent),
    .sequence_end_o (m_axis_tlast)
  );

  assign m_axis_tdata = {(OUT_W - OUT_BITS)'(0), is_frequent, match_total,
                         window_start, window_match};

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready
  ) else $error("input accepted while a sample is still being ranked");

  a_frequent_only_at_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OUT_FREQ_LSB]) |-> m_axis_tlast
  ) else $error("frequent flag outside the last beat of a sequence");

  a_match_counted: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OUT_MATCH_LSB]) |->
      (m_axis_tdata[OUT_TOTAL_LSB +: CNT_W] != '0)
  ) else $error("window match reported with zero match count");

endmodule

`default_nettype wire

// File: rtl/aopwm_ctrl.sv
`default_nettype none

module aopwm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  aopwm_pkg::status_t status_i,
  output aopwm_pkg::cmd_t    cmd_o
);
  import aopwm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (status_i.last_pos) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CALC: begin
        cmd_o.step = 1'b1;
      end
      ST_FINISH: begin
        cmd_o.finish = status_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/aopwm_datapath.sv
`default_nettype none

module aopwm_datapath #(
  parameter int MAX_LEN      = aopwm_pkg::DEF_MAX_LEN,
  parameter int SAMPLE_WIDTH = aopwm_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  aopwm_pkg::cmd_t                  cmd_i,
  output aopwm_pkg::status_t               status_o,
  input  logic                             cfg_we_i,
  input  logic [aopwm_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [aopwm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic [SAMPLE_WIDTH-1:0]          sample_i,
  input  logic                             last_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             window_match_o,
  output logic [aopwm_pkg::CNT_W-1:0]      window_start_o,
  output logic [aopwm_pkg::CNT_W-1:0]      match_total_o,
  output logic                             is_frequent_o,
  output logic                             sequence_end_o
);
  import aopwm_pkg::*;

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam int POS_W = $clog2(MAX_LEN);
  localparam int TOT_W = $clog2(MAX_LEN * MAX_LEN + 1);
  localparam int CMP_W = TOT_W + 8;

  logic [3:0]       cfg_len_q;
  logic [31:0]      cfg_ranks_q;
  logic [7:0]       cfg_max_dev_q;
  logic [7:0]       cfg_max_total_q;
  logic [CNT_W-1:0] cfg_min_sup_q;

  logic [SAMPLE_WIDTH-1:0] win_q [MAX_LEN];

  logic [LEN_W-1:0] fill_q;
  logic [CNT_W-1:0] idx_q, cur_idx_q, cnt_q;
  logic             last_q;
  logic [POS_W-1:0] pos_q;
  logic             fail_q;
  logic [TOT_W-1:0] total_q;

  logic             out_valid_q;
  logic             match_q, freq_q, end_q;
  logic [CNT_W-1:0] start_q, mtotal_q;

  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        win_idx;
  logic [SAMPLE_WIDTH-1:0] kp;
  logic [3:0]              vp, vq;
  logic [LEN_W-1:0]        wr, pr, dev;
  logic                    dup, dev_fail;
  logic                    full, hit;
  logic [CNT_W-1:0]        cnt_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q       <= 4'd2;
      cfg_ranks_q     <= 32'd33;
      cfg_max_dev_q   <= 8'd0;
      cfg_max_total_q <= 8'd0;
      cfg_min_sup_q   <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_PATTERN_LEN:   cfg_len_q       <= cfg_wdata_i[3:0];
        REG_PATTERN_RANKS: cfg_ranks_q     <= cfg_wdata_i;
        REG_MAX_RANK_DEV:  cfg_max_dev_q   <= cfg_wdata_i[7:0];
        REG_MAX_TOTAL_DEV: cfg_max_total_q <= cfg_wdata_i[7:0];
        REG_MIN_SUPPORT:   cfg_min_sup_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_len_q < 4'd2) begin
      len = LEN_W'(2);
    end else if (cfg_len_q > 4'(MAX_LEN)) begin
      len = LEN_W'(MAX_LEN);
    end else begin
      len = cfg_len_q[LEN_W-1:0];
    end
  end

  // rank of one window position per cycle
  always_comb begin
    win_idx = len - LEN_W'(1) - LEN_W'(pos_q);
    kp      = win_q[win_idx[POS_W-1:0]];
    vp      = pat_value(cfg_ranks_q, int'(pos_q));
    wr      = LEN_W'(1);
    pr      = LEN_W'(1);
    dup     = 1'b0;
    vq      = '0;
    for (int j = 0; j < MAX_LEN; j++) begin
      vq = pat_value(cfg_ranks_q, j);
      if (LEN_W'(j) < len) begin
        if ($signed(win_q[j]) < $signed(kp)) wr = wr + LEN_W'(1);
        if ((LEN_W'(j) != win_idx) && (win_q[j] == kp)) dup = 1'b1;
        if ((vq < vp) || ((vq == vp) && (j < int'(pos_q)))) pr = pr + LEN_W'(1);
      end
    end
    dev      = (wr > pr) ? (wr - pr) : (pr - wr);
    dev_fail = CMP_W'(dev) > CMP_W'(cfg_max_dev_q);
  end

  assign status_o.last_pos = (LEN_W'(pos_q) == (len - LEN_W'(1)));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign full    = (fill_q >= len);
  assign hit     = full && !fail_q && (CMP_W'(total_q) <= CMP_W'(cfg_max_total_q));
  assign cnt_new = (hit && (cnt_q != '1)) ? (cnt_q + CNT_W'(1)) : cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int i = MAX_LEN - 1; i > 0; i--) begin
        win_q[i] <= win_q[i-1];
      end
      win_q[0] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      idx_q     <= '0;
      cur_idx_q <= '0;
      cnt_q     <= '0;
      last_q    <= 1'b0;
      pos_q     <= '0;
      fail_q    <= 1'b0;
      total_q   <= '0;
    end else begin
      if (cmd_i.accept) begin
        if (fill_q != LEN_W'(MAX_LEN)) fill_q <= fill_q + LEN_W'(1);
        idx_q     <= idx_q + CNT_W'(1);
        cur_idx_q <= idx_q;
        last_q    <= last_i;
        pos_q     <= '0;
        fail_q    <= 1'b0;
        total_q   <= '0;
      end
      if (cmd_i.step) begin
        pos_q   <= pos_q + POS_W'(1);
        fail_q  <= fail_q | dup | dev_fail;
        total_q <= total_q + TOT_W'(dev);
      end
      if (cmd_i.finish) begin
        if (last_q) begin
          fill_q <= '0;
          idx_q  <= '0;
          cnt_q  <= '0;
        end else begin
          cnt_q  <= cnt_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      match_q  <= hit;
      start_q  <= full ? (cur_idx_q - CNT_W'(len - LEN_W'(1))) : '0;
      mtotal_q <= cnt_new;
      freq_q   <= last_q && (cnt_new >= cfg_min_sup_q);
      end_q    <= last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_match_o = match_q;
  assign window_start_o = start_q;
  assign match_total_o  = mtotal_q;
  assign is_frequent_o  = freq_q;
  assign sequence_end_o = end_q;

endmodule

`default_nettype wire

// File: test/approx_order_preserving_window_match_top_tb.sv
module approx_order_preserving_window_match_top_tb;
  import aopwm_pkg::*;

  localparam int MAXL         = DEF_MAX_LEN;
  localparam int SETTLE       = 2 * MAXL + 8;
  localparam int LIMIT_CYCLES = 400000;
  localparam int RAND_ITEMS   = 400;

  typedef struct packed {
    logic        hit;
    logic [31:0] start;
    logic [31:0] total;
    logic        freq;
    logic        seq_end;
  } match_beat_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata  = '0;  // sample
  logic                  s_axis_tlast  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // window_match, window_start[31:0], match_total[31:0], is_frequent, zero pad
  logic [OUT_W-1:0]      m_axis_tdata;
  logic                  m_axis_tlast;

  approx_order_preserving_window_match_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirrored config and sequence state
  logic [3:0]         cfg_len;
  logic [31:0]        cfg_ranks;
  logic [7:0]         cfg_rank_dev;
  logic [7:0]         cfg_total_dev;
  logic [31:0]        cfg_support;
  logic signed [31:0] win_hist [MAXL];
  logic [3:0]         held_cnt;
  logic [31:0]        seq_pos;
  logic [31:0]        hit_cnt;

  match_beat_t expected_beats [$];
  match_beat_t want_beat;
  int unsigned errors    = 0;
  int unsigned sent_cnt  = 0;
  int unsigned cycle_cnt = 0;
  int unsigned snk_wait  = 0;
  bit          src_gaps   = 1'b1;
  bit          snk_stalls = 1'b1;

  function automatic int unsigned active_len();
    if (cfg_len < 2) return 2;
    if (cfg_len > MAXL) return MAXL;
    return cfg_len;
  endfunction

  // rank of pattern position p; equal nibbles ordered by position
  function automatic int unsigned pattern_rank(int unsigned p, int unsigned len);
    int unsigned r;
    logic [3:0]  vp;
    logic [3:0]  vq;
    r  = 1;
    vp = cfg_ranks[4*p +: 4];
    for (int unsigned q = 0; q < len; q++) begin
      vq = cfg_ranks[4*q +: 4];
      if (vq < vp || (vq == vp && q < p)) r++;
    end
    return r;
  endfunction

  // position 0 is the oldest sample of the window
  function automatic logic window_fits(int unsigned len);
    int unsigned wr;
    int unsigned pr;
    int unsigned dev;
    int unsigned total;
    total = 0;
    for (int unsigned p = 0; p < len; p++) begin
      for (int unsigned q = p + 1; q < len; q++) begin
        if (win_hist[len-1-p] == win_hist[len-1-q]) return 1'b0;
      end
    end
    for (int unsigned p = 0; p < len; p++) begin
      wr = 1;
      for (int unsigned q = 0; q < len; q++) begin
        if (win_hist[len-1-q] < win_hist[len-1-p]) wr++;
      end
      pr  = pattern_rank(p, len);
      dev = (wr > pr) ? wr - pr : pr - wr;
      if (dev > cfg_rank_dev) return 1'b0;
      total += dev;
    end
    return total <= cfg_total_dev;
  endfunction

  function automatic match_beat_t predict_window_beat(logic [31:0] smp, logic is_last);
    match_beat_t b;
    int unsigned len;
    logic [31:0] idx;
    b   = '0;
    len = active_len();
    idx = seq_pos;
    for (int i = MAXL - 1; i > 0; i--) win_hist[i] = win_hist[i-1];
    win_hist[0] = smp;
    if (held_cnt < MAXL) held_cnt++;
    seq_pos = idx + 1;
    if (held_cnt >= len) begin
      b.start = idx - (len - 1);
      if (window_fits(len)) begin
        b.hit = 1'b1;
        if (hit_cnt != '1) hit_cnt++;
      end
    end
    b.total   = hit_cnt;
    b.seq_end = is_last;
    if (is_last) begin
      b.freq   = (hit_cnt >= cfg_support);
      held_cnt = '0;
      seq_pos  = '0;
      hit_cnt  = '0;
    end
    return b;
  endfunction

  function automatic logic [31:0] shuffled_ranks();
    int unsigned a [8];
    int unsigned j;
    int unsigned t;
    logic [31:0] r;
    for (int i = 0; i < 8; i++) a[i] = i + 1;
    for (int i = 7; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = a[i];
      a[i] = a[j];
      a[j] = t;
    end
    for (int i = 0; i < 8; i++) r[4*i +: 4] = a[i][3:0];
    return r;
  endfunction

  task automatic set_config(input logic [31:0] len, input logic [31:0] ranks,
                            input logic [31:0] rdev, input logic [31:0] tdev,
                            input logic [31:0] support);
    logic [31:0] vals [5];
    cfg_reg_e    regs [5];
    vals = '{len, ranks, rdev, tdev, support};
    regs = '{REG_PATTERN_LEN, REG_PATTERN_RANKS, REG_MAX_RANK_DEV, REG_MAX_TOTAL_DEV,
             REG_MIN_SUPPORT};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_addr_i  = regs[i];
      cfg_wdata_i = vals[i];
      @(posedge clk_i);
      case (regs[i])
        REG_PATTERN_LEN:   cfg_len       = vals[i][3:0];
        REG_PATTERN_RANKS: cfg_ranks     = vals[i];
        REG_MAX_RANK_DEV:  cfg_rank_dev  = vals[i][7:0];
        REG_MAX_TOTAL_DEV: cfg_total_dev = vals[i][7:0];
        REG_MIN_SUPPORT:   cfg_support   = vals[i];
        default: ;
      endcase
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_sample(input logic [31:0] smp, input logic is_last);
    int unsigned gap;
    match_beat_t next_beat;
    gap = src_gaps ? $urandom_range(0, 11) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = smp;
    s_axis_tlast  = is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    next_beat = predict_window_beat(smp, is_last);
    expected_beats.insert(expected_beats.size(), next_beat);
    sent_cnt++;
  endtask

  // stop sending and let every outstanding result drain
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic test_default_config();
    send_sample(32'h8000_0000, 1'b0);  // window not yet full
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);  // duplicate values
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b1);
    wait_idle();
  endtask

  task automatic test_length_extremes();
    set_config(32'd0, 32'h0000_0012, 32'd0, 32'd0, 32'd0);
    send_sample(32'd5, 1'b0);
    send_sample(32'd3, 1'b0);
    send_sample(32'd1, 1'b1);
    wait_idle();
    // all nibbles tied: pattern falls back to position order
    set_config(32'd15, 32'hFFFF_FFFF, 32'd255, 32'd255, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) send_sample($urandom(), i == 8);
    wait_idle();
  endtask

  task automatic test_length_change_mid_sequence();
    set_config(32'd3, 32'h0000_0213, 32'd1, 32'd2, 32'd1);
    for (int i = 0; i < 4; i++) send_sample($urandom_range(0, 15) - 8, 1'b0);
    wait_idle();
    set_config(32'd9, shuffled_ranks(), 32'd2, 32'd6, 32'd1);
    for (int i = 0; i < 4; i++) send_sample($urandom(), i == 3);
    wait_idle();
  endtask

  task automatic test_random_sequences();
    int unsigned        goal;
    int unsigned        seq_len;
    int unsigned        step;
    int unsigned        len;
    int unsigned        phase;
    bit                 shaped;
    logic signed [31:0] base;
    logic [31:0]        smp;
    logic [31:0]        rlen;
    logic [31:0]        rranks;
    logic [31:0]        rdev;
    logic [31:0]        tdev;
    logic [31:0]        sup;
    goal = sent_cnt + RAND_ITEMS;
    while (sent_cnt < goal) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        case ($urandom_range(0, 9))
          0:       rlen = 0;
          1:       rlen = 1;
          2:       rlen = $urandom_range(9, 15);
          default: rlen = $urandom_range(2, 8);
        endcase
        rranks = ($urandom_range(0, 3) == 0) ? $urandom() : shuffled_ranks();
        case ($urandom_range(0, 4))
          0:       rdev = 0;
          1:       rdev = 1;
          2:       rdev = 2;
          3:       rdev = 3;
          default: rdev = $urandom();
        endcase
        case ($urandom_range(0, 3))
          0:       tdev = 0;
          1:       tdev = $urandom_range(0, 8);
          2:       tdev = 255;
          default: tdev = $urandom_range(0, 255);
        endcase
        case ($urandom_range(0, 3))
          0:       sup = 0;
          1:       sup = $urandom_range(1, 6);
          2:       sup = 32'hFFFF_FFFF;
          default: sup = $urandom();
        endcase
        set_config(rlen, rranks, rdev, tdev, sup);
      end
      src_gaps   = ($urandom_range(0, 3) != 0);
      snk_stalls = ($urandom_range(0, 3) != 0);
      shaped     = ($urandom_range(0, 9) < 7);
      seq_len    = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 24);
      len        = active_len();
      base       = $signed($urandom()) >>> 4;
      step       = $urandom_range(1, 4096);
      phase      = $urandom_range(0, len - 1);
      for (int unsigned k = 0; k < seq_len; k++) begin
        if (shaped && $urandom_range(0, 9) != 0) begin
          smp = base + pattern_rank((k + phase) % len, len) * step + $urandom_range(0, step - 1);
        end else if ($urandom_range(0, 1) == 0) begin
          smp = $urandom();
        end else begin
          smp = $urandom_range(0, 7) - 4;
        end
        // a few sequences stay open across the next config change
        send_sample(smp, (k == seq_len - 1) && ($urandom_range(0, 9) != 0));
      end
    end
    src_gaps   = 1'b1;
    snk_stalls = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk_i) begin
    if (snk_wait > 0) begin
      m_axis_tready = 1'b0;
      snk_wait--;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      snk_wait = snk_stalls ? $urandom_range(0, 11) : 0;
      if (expected_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat, expected none got %0h", $time, m_axis_tdata);
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("window_match", want_beat.hit, m_axis_tdata[OUT_MATCH_LSB]);
        check_field("window_start", want_beat.start, m_axis_tdata[OUT_START_LSB +: CNT_W]);
        check_field("match_total", want_beat.total, m_axis_tdata[OUT_TOTAL_LSB +: CNT_W]);
        check_field("is_frequent", want_beat.freq, m_axis_tdata[OUT_FREQ_LSB]);
        check_field("sequence_end", want_beat.seq_end, m_axis_tlast);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    cfg_len       = 4'd2;
    cfg_ranks     = 32'd33;
    cfg_rank_dev  = '0;
    cfg_total_dev = '0;
    cfg_support   = 32'd1;
    for (int i = 0; i < MAXL; i++) win_hist[i] = '0;
    held_cnt = '0;
    seq_pos  = '0;
    hit_cnt  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_default_config();
    test_length_extremes();
    test_length_change_mid_sequence();
    test_random_sequences();
    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/aopwm_pkg.sv
rtl/aopwm_ctrl.sv
rtl/aopwm_datapath.sv
rtl/approx_order_preserving_window_match_top.sv
test/approx_order_preserving_window_match_top_tb.sv
